// ===== rtl/core/noise_biome_tile_generator_core_defines.svh =====
// Assertion macros used by the checker file of the tile generator.
// No dependencies; expects clk, and for NBTG_ASSERT also rst_n, in the scope of each use.
`ifndef NOISE_BIOME_TILE_GENERATOR_CORE_DEFINES_SVH
`define NOISE_BIOME_TILE_GENERATOR_CORE_DEFINES_SVH

// checked only outside reset
`define NBTG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("nbtg check failed");

// checked on every edge, reset included
`define NBTG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("nbtg check failed");

`endif

// ===== rtl/core/nbtg_pkg.sv =====
// Package of the noise biome tile generator: types, register codes, hash and
// weight constants, the cosine table builder. No dependencies.
package nbtg_pkg;

  localparam int TILE_X_W = 9;
  localparam int TILE_Y_W = 8;
  localparam int BIOME_W  = 4;
  localparam int VAL_W    = 18;
  localparam int CFG_W    = 16;
  localparam int CFG_N    = 8;
  localparam int CFG_AW   = $clog2(CFG_N);
  localparam int COORD_W  = 10;
  localparam int CELL_W   = 6;
  localparam int NPRE_W   = 12;
  localparam int NHASH_W  = 25;
  localparam int LAT_ROWS = 256;
  localparam int MAP_HEIGHT_DEF = 256;

  localparam logic [31:0] HASH_K1 = 32'd15731;
  localparam logic [31:0] HASH_K2 = 32'd789221;
  localparam logic [31:0] HASH_K3 = 32'd1376312589;
  localparam logic [NPRE_W-1:0] HASH_ROW = 12'd57;

  localparam logic signed [31:0] Q30_ONE_S = 32'sd1073741824;
  localparam logic signed [16:0] TEMP_SCALE = 17'sd13107;

  typedef enum logic [CFG_AW-1:0] {
    REG_OCEAN   = 3'd0,
    REG_VOLCANO = 3'd1,
    REG_MOUNT   = 3'd2,
    REG_ICE     = 3'd3,
    REG_TUNDRA  = 3'd4,
    REG_HOT     = 3'd5,
    REG_DRY     = 3'd6,
    REG_WET     = 3'd7
  } cfg_idx_t;

  typedef enum logic [BIOME_W-1:0] {
    BIOME_OCEAN     = 4'd0,
    BIOME_VOLCANO   = 4'd1,
    BIOME_MOUNTAIN  = 4'd2,
    BIOME_ICE       = 4'd3,
    BIOME_TUNDRA    = 4'd4,
    BIOME_DESERT    = 4'd5,
    BIOME_JUNGLE    = 4'd6,
    BIOME_FOREST    = 4'd7,
    BIOME_GRASSLAND = 4'd8,
    BIOME_MIXED     = 4'd9
  } biome_t;

  typedef logic [CFG_W-1:0] cfg_regs_t [CFG_N];
  localparam cfg_regs_t CFG_RESET = '{
    16'd29491, 16'd55706, 16'd49152, 16'd13107,
    16'd19661, 16'd45875, 16'd19661, 16'd39322
  };

  typedef logic signed [16:0] oct_wt_t [3];
  localparam oct_wt_t OCT_WT = '{17'sd39322, 17'sd19661, 17'sd6554};

  typedef logic [COORD_W-1:0] field_off_t [3];
  localparam field_off_t FIELD_OFF = '{10'd0, 10'd100, 10'd200};

  typedef logic signed [VAL_W-1:0] cos_rom_t [LAT_ROWS];

  // cell index of one octave: floor(v/100), floor(v/50), floor(v/20), v < 1024
  function automatic logic [CELL_W-1:0] oct_cell(logic [COORD_W-1:0] v, logic [1:0] o);
    logic [21:0] p;
    logic [CELL_W-1:0] c;
    case (o)
      2'd0: begin
        p = 22'(v) * 22'd1311;
        c = CELL_W'(p >> 17);
      end
      2'd1: begin
        p = 22'(v) * 22'd1311;
        c = CELL_W'(p >> 16);
      end
      default: begin
        p = 22'(v) * 22'd3277;
        c = CELL_W'(p >> 16);
      end
    endcase
    return c;
  endfunction

  // signed quotient truncated toward zero, shift and subtract; table building only
  function automatic longint div_trunc(longint a, longint b);
    longint ua;
    longint ub;
    longint q;
    longint r;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r <<< 1) | ((ua >>> i) & 64'sd1);
      q = q <<< 1;
      if (r >= ub) begin
        r = r - ub;
        q = q | 64'sd1;
      end
    end
    return neg ? -q : q;
  endfunction

  // cos(pi*i/256) in Q16 from a fixed-point Taylor series, evaluated at elaboration
  function automatic cos_rom_t build_cos();
    cos_rom_t rom;
    longint k;
    longint th;
    longint th2;
    longint term;
    longint sum;
    longint q;
    bit neg;
    for (int i = 0; i < LAT_ROWS; i++) begin
      neg = 1'b0;
      k = longint'(i);
      if (k > 128) begin
        k = 256 - k;
        neg = 1'b1;
      end
      th = (k * 64'sd3373259426) / 256;
      th2 = (th * th) / 64'sd1073741824;
      term = 64'sd1073741824;
      sum = 64'sd1073741824;
      for (longint j = 1; j <= 10; j++) begin
        term = div_trunc(-((term * th2) / 64'sd1073741824), (2 * j - 1) * (2 * j));
        sum += term;
      end
      if (sum < 0) sum = 0;
      q = (sum + 8192) / 16384;
      rom[i] = neg ? VAL_W'(-q) : VAL_W'(q);
    end
    return rom;
  endfunction

endpackage

// ===== rtl/core/nbtg_if.sv =====
// Valid/ready channel interfaces of the tile generator (coordinate in, result out).
// Depends on nbtg_pkg.
interface nbtg_in_if import nbtg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TILE_X_W-1:0] tile_x;
  logic [TILE_Y_W-1:0] tile_y;
  modport source (output valid, tile_x, tile_y, input ready);
  modport sink (input valid, tile_x, tile_y, output ready);
endinterface

interface nbtg_out_if import nbtg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [BIOME_W-1:0]      biome;
  logic signed [VAL_W-1:0] elevation;
  logic signed [VAL_W-1:0] moisture;
  logic signed [VAL_W-1:0] temperature;
  modport source (output valid, biome, elevation, moisture, temperature, input ready);
  modport sink (input valid, biome, elevation, moisture, temperature, output ready);
endinterface

// ===== rtl/core/noise_biome_tile_generator_core.sv =====
// Tile biome generator: fractal hash value noise for elevation, moisture and
// temperature, then threshold classification. Depends on nbtg_pkg, nbtg_if.
//
// Usage:
//   in_chan carries one tile coordinate (tile_x, tile_y) per item; out_chan
//   returns its biome code and the three signed Q16 field values.
//   cfg_we/cfg_addr/cfg_wdata write the eight 16-bit thresholds; write them
//   only while no item is in flight. Writes take effect at once.
//   Throughput is one item per cycle while out_chan.ready is high: 27 hash
//   lanes, each with its three 32-bit multiply stages, work in parallel in an
//   11-stage pipeline. Every stage has its own valid bit and loads when it is
//   empty or the stage after it moves, so bubbles close up; when out_chan.ready
//   is low the result holds and in_chan keeps accepting until the pipeline is
//   full. Reset (rst_n low at a clock edge) empties the pipeline and loads
//   the default thresholds. MAP_HEIGHT sets the row to latitude mapping.
module noise_biome_tile_generator_core
  import nbtg_pkg::*;
#(
  parameter int MAP_HEIGHT = MAP_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  nbtg_in_if.sink           in_chan,
  nbtg_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int NSTG = 11;
  localparam cos_rom_t COS_ROM = build_cos();

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  cfg_regs_t cfg_r;

  logic [TILE_Y_W-1:0] ylat_r [9];
  logic [COORD_W-1:0]  px_r [3];
  logic [COORD_W-1:0]  py_r [3];
  logic [CELL_W-1:0]   cx_r [3][3];
  logic [CELL_W-1:0]   cy_r [3][3];
  logic [NHASH_W-1:0]  n_r  [3][3][3];
  logic [NHASH_W-1:0]  na_r [3][3][3];
  logic [31:0]         nn_r [3][3][3];
  logic [NHASH_W-1:0]  nb_r [3][3][3];
  logic [31:0]         t_r  [3][3][3];
  logic signed [31:0]  lat_r [3][3][3];
  logic signed [31:0]  oct_r [3][3];
  logic signed [47:0]  prod_r [3][3];
  logic signed [31:0]  frac_r [3];
  logic signed [VAL_W-1:0] elev_r;
  logic signed [VAL_W-1:0] moist_r;
  logic signed [VAL_W-1:0] temp_r;
  logic [BIOME_W-1:0]      biome_r;
  logic signed [VAL_W-1:0] out_elev_r;
  logic signed [VAL_W-1:0] out_moist_r;
  logic signed [VAL_W-1:0] out_temp_r;

  logic signed [VAL_W-1:0] temp_base [LAT_ROWS];
  biome_t biome_nxt;

  for (genvar g = 0; g < LAT_ROWS; g++) begin : g_lat
    localparam int LI  = (g * LAT_ROWS) / MAP_HEIGHT;
    localparam int LIS = (LI > LAT_ROWS - 1) ? LAT_ROWS - 1 : LI;
    assign temp_base[g] = COS_ROM[LIS];
  end

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_chan.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_chan.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_chan.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r[cfg_addr] <= cfg_wdata;
    end
  end

  // stage 0: field points
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ylat_r[0] <= in_chan.tile_y;
      for (int f = 0; f < 3; f++) begin
        px_r[f] <= COORD_W'(in_chan.tile_x) + FIELD_OFF[f];
        py_r[f] <= COORD_W'(in_chan.tile_y) + FIELD_OFF[f];
      end
    end
    for (int k = 1; k < 9; k++) begin
      if (en[k]) ylat_r[k] <= ylat_r[k-1];
    end
  end

  // stage 1: octave cells
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int f = 0; f < 3; f++) begin
        for (int o = 0; o < 3; o++) begin
          cx_r[f][o] <= oct_cell(px_r[f], 2'(o));
          cy_r[f][o] <= oct_cell(py_r[f], 2'(o));
        end
      end
    end
  end

  // stage 2: hash seeds for corner, right and lower neighbor
  always_ff @(posedge clk) begin
    logic [NPRE_W-1:0] hx;
    logic [NPRE_W-1:0] hy;
    logic [NPRE_W-1:0] hn;
    if (en[2]) begin
      for (int f = 0; f < 3; f++) begin
        for (int o = 0; o < 3; o++) begin
          for (int p = 0; p < 3; p++) begin
            hx = NPRE_W'(cx_r[f][o]) + ((p == 1) ? NPRE_W'(1) : NPRE_W'(0));
            hy = NPRE_W'(cy_r[f][o]) + ((p == 2) ? NPRE_W'(1) : NPRE_W'(0));
            hn = hx + hy * HASH_ROW;
            n_r[f][o][p] <= {hn, 13'd0} ^ NHASH_W'(hn);
          end
        end
      end
    end
  end

  // stages 3..5: hash multiplies
  always_ff @(posedge clk) begin
    logic [31:0] u;
    for (int f = 0; f < 3; f++) begin
      for (int o = 0; o < 3; o++) begin
        for (int p = 0; p < 3; p++) begin
          if (en[3]) begin
            nn_r[f][o][p] <= 32'(n_r[f][o][p]) * 32'(n_r[f][o][p]);
            na_r[f][o][p] <= n_r[f][o][p];
          end
          if (en[4]) begin
            t_r[f][o][p]  <= nn_r[f][o][p] * HASH_K1 + HASH_K2;
            nb_r[f][o][p] <= na_r[f][o][p];
          end
          if (en[5]) begin
            u = 32'(nb_r[f][o][p]) * t_r[f][o][p] + HASH_K3;
            lat_r[f][o][p] <= Q30_ONE_S - $signed({1'b0, u[30:0]});
          end
        end
      end
    end
  end

  // stage 6: octave smoothing, stage 7: octave weights
  always_ff @(posedge clk) begin
    logic signed [33:0] s;
    for (int f = 0; f < 3; f++) begin
      for (int o = 0; o < 3; o++) begin
        if (en[6]) begin
          s = (34'(lat_r[f][o][0]) <<< 1) + 34'(lat_r[f][o][1]) + 34'(lat_r[f][o][2]);
          s = s + (s[33] ? 34'sd3 : 34'sd0);
          oct_r[f][o] <= 32'(s >>> 2);
        end
        if (en[7]) prod_r[f][o] <= oct_r[f][o] * OCT_WT[o];
      end
    end
  end

  // stage 8: fractal sums
  always_ff @(posedge clk) begin
    logic signed [47:0] acc;
    if (en[8]) begin
      for (int f = 0; f < 3; f++) begin
        acc = prod_r[f][0] + prod_r[f][1] + prod_r[f][2];
        acc = acc + (acc[47] ? 48'sd65535 : 48'sd0);
        frac_r[f] <= 32'(acc >>> 16);
      end
    end
  end

  // stage 9: field values
  always_ff @(posedge clk) begin
    logic signed [32:0] e;
    logic signed [32:0] m;
    logic signed [47:0] tp;
    if (en[9]) begin
      e = 33'(frac_r[0]) + 33'(Q30_ONE_S);
      e = e + (e[32] ? 33'sd32767 : 33'sd0);
      m = 33'(frac_r[1]) + 33'(Q30_ONE_S);
      m = m + (m[32] ? 33'sd32767 : 33'sd0);
      tp = frac_r[2] * TEMP_SCALE;
      tp = tp + (tp[47] ? 48'sd1073741823 : 48'sd0);
      elev_r  <= VAL_W'(e >>> 15);
      moist_r <= VAL_W'(m >>> 15);
      temp_r  <= temp_base[ylat_r[8]] + VAL_W'(tp >>> 30);
    end
  end

  // stage 10: classification
  always_comb begin
    logic signed [VAL_W-1:0] th [CFG_N];
    for (int i = 0; i < CFG_N; i++) th[i] = $signed(VAL_W'(cfg_r[i]));
    priority if (elev_r < th[REG_OCEAN]) biome_nxt = BIOME_OCEAN;
    else if (elev_r > th[REG_VOLCANO]) biome_nxt = BIOME_VOLCANO;
    else if (elev_r > th[REG_MOUNT]) biome_nxt = BIOME_MOUNTAIN;
    else if (temp_r < th[REG_ICE]) biome_nxt = BIOME_ICE;
    else if (temp_r < th[REG_TUNDRA]) biome_nxt = BIOME_TUNDRA;
    else if (temp_r > th[REG_HOT] && moist_r < th[REG_DRY]) biome_nxt = BIOME_DESERT;
    else if (temp_r > th[REG_HOT] && moist_r > th[REG_WET]) biome_nxt = BIOME_JUNGLE;
    else if (moist_r > th[REG_WET]) biome_nxt = BIOME_FOREST;
    else if (moist_r < th[REG_DRY]) biome_nxt = BIOME_GRASSLAND;
    else biome_nxt = BIOME_MIXED;
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      biome_r     <= biome_nxt;
      out_elev_r  <= elev_r;
      out_moist_r <= moist_r;
      out_temp_r  <= temp_r;
    end
  end

  assign out_chan.valid       = v_r[NSTG-1];
  assign out_chan.biome       = biome_r;
  assign out_chan.elevation   = out_elev_r;
  assign out_chan.moisture    = out_moist_r;
  assign out_chan.temperature = out_temp_r;

endmodule

// ===== rtl/core/nbtg_checker.sv =====
// Port-level checks of the tile generator result channel, bound to the top level.
// Depends on nbtg_pkg and noise_biome_tile_generator_core_defines.svh.
`include "noise_biome_tile_generator_core_defines.svh"

module nbtg_checker
  import nbtg_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [BIOME_W-1:0]      out_biome,
  input logic signed [VAL_W-1:0] out_elevation,
  input logic signed [VAL_W-1:0] out_moisture,
  input logic signed [VAL_W-1:0] out_temperature
);

  `NBTG_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_biome) && $stable(out_elevation) && $stable(out_moisture) && $stable(out_temperature))
  `NBTG_ASSERT(a_biome_code, out_valid |-> out_biome <= BIOME_MIXED)
  `NBTG_ASSERT(a_elev_span, out_valid |-> !out_elevation[VAL_W-1] && out_elevation <= 18'sd65536)
  `NBTG_ASSERT_ALWAYS(a_moist_span, out_valid === 1'b1 |-> !out_moisture[VAL_W-1] && out_moisture <= 18'sd65536)

endmodule

bind noise_biome_tile_generator_core nbtg_checker u_nbtg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_biome       (out_chan.biome),
  .out_elevation   (out_chan.elevation),
  .out_moisture    (out_chan.moisture),
  .out_temperature (out_chan.temperature)
);

// ===== bench/noise_biome_tile_generator_core_test.sv =====
// Testbench of the tile biome generator: random and directed tile coordinates,
// threshold changes between phases, results checked against a local predictor.
// Depends on nbtg_pkg, nbtg_if and noise_biome_tile_generator_core.
module noise_biome_tile_generator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nbtg_pkg::*;

  typedef struct {
    biome_t                  biome;
    logic signed [VAL_W-1:0] elevation;
    logic signed [VAL_W-1:0] moisture;
    logic signed [VAL_W-1:0] temperature;
  } tile_result_t;

  localparam int LATENCY = 11;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  nbtg_in_if in_chan ();
  nbtg_out_if out_chan ();

  noise_biome_tile_generator_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  logic [CFG_W-1:0] thresholds [CFG_N];
  tile_result_t pending_tiles [$];
  int err_count = 0;
  longint cycle_count = 0;
  longint cos_q16 [256];

  initial begin
    in_chan.valid = 1'b0;
    in_chan.tile_x = '0;
    in_chan.tile_y = '0;
    out_chan.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic longint hash_q30(longint unsigned px, longint unsigned py);
    logic [31:0] n;
    logic [31:0] v;
    n = 32'(px) + 32'(py) * 32'd57;
    n = (n << 13) ^ n;
    v = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
    return 64'sd1073741824 - longint'(v);
  endfunction

  function automatic longint cell_smooth(longint unsigned cx, longint unsigned cy);
    return (2 * hash_q30(cx, cy) + hash_q30(cx + 1, cy) + hash_q30(cx, cy + 1)) / 4;
  endfunction

  function automatic longint fractal_q30(longint unsigned px, longint unsigned py);
    return (39322 * cell_smooth(px / 100, py / 100) + 19661 * cell_smooth(px / 50, py / 50)
            + 6554 * cell_smooth(px / 20, py / 20)) / 65536;
  endfunction

  function automatic void fill_cos_table();
    longint k, th, th2, term, sum, q;
    bit neg;
    for (int i = 0; i < 256; i++) begin
      neg = 1'b0;
      k = i;
      if (k > 128) begin
        k = 256 - k;
        neg = 1'b1;
      end
      th = (k * 64'sd3373259426) / 256;
      th2 = (th * th) / 64'sd1073741824;
      term = 64'sd1073741824;
      sum = term;
      for (longint j = 1; j <= 10; j++) begin
        term = -((term * th2) / 64'sd1073741824) / ((2 * j - 1) * (2 * j));
        sum += term;
      end
      if (sum < 0) sum = 0;
      q = (sum + 8192) / 16384;
      cos_q16[i] = neg ? -q : q;
    end
  endfunction

  function automatic tile_result_t classify_tile(logic [TILE_X_W-1:0] tx,
                                                 logic [TILE_Y_W-1:0] ty);
    tile_result_t r;
    longint elev, moist, temp, lat;
    longint unsigned x, y;
    longint lim [CFG_N];
    for (int i = 0; i < CFG_N; i++) lim[i] = longint'(thresholds[i]);
    x = tx;
    y = ty;
    elev = (fractal_q30(x, y) + 64'sd1073741824) / 32768;
    moist = (fractal_q30(x + 100, y + 100) + 64'sd1073741824) / 32768;
    lat = (y * 256) / MAP_HEIGHT_DEF;
    if (lat > 255) lat = 255;
    temp = cos_q16[lat] + (fractal_q30(x + 200, y + 200) * 13107) / 64'sd1073741824;
    if (elev < lim[REG_OCEAN]) r.biome = BIOME_OCEAN;
    else if (elev > lim[REG_VOLCANO]) r.biome = BIOME_VOLCANO;
    else if (elev > lim[REG_MOUNT]) r.biome = BIOME_MOUNTAIN;
    else if (temp < lim[REG_ICE]) r.biome = BIOME_ICE;
    else if (temp < lim[REG_TUNDRA]) r.biome = BIOME_TUNDRA;
    else if (temp > lim[REG_HOT] && moist < lim[REG_DRY]) r.biome = BIOME_DESERT;
    else if (temp > lim[REG_HOT] && moist > lim[REG_WET]) r.biome = BIOME_JUNGLE;
    else if (moist > lim[REG_WET]) r.biome = BIOME_FOREST;
    else if (moist < lim[REG_DRY]) r.biome = BIOME_GRASSLAND;
    else r.biome = BIOME_MIXED;
    r.elevation = VAL_W'(elev);
    r.moisture = VAL_W'(moist);
    r.temperature = VAL_W'(temp);
    return r;
  endfunction

  // result checker with random stall per item
  initial begin
    int stall;
    tile_result_t exp_r;
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, 3);
      if (($urandom_range(0, 3) == 0)) stall = 0;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_chan.valid));
      if (pending_tiles.size() == 0) begin
        $error("unexpected result biome %0d", out_chan.biome);
        err_count++;
      end else begin
        exp_r = pending_tiles.pop_front();
        if (out_chan.biome !== exp_r.biome) begin
          $error("biome exp %0d got %0d", exp_r.biome, out_chan.biome);
          err_count++;
        end
        if (out_chan.elevation !== exp_r.elevation) begin
          $error("elevation exp %0d got %0d", exp_r.elevation, out_chan.elevation);
          err_count++;
        end
        if (out_chan.moisture !== exp_r.moisture) begin
          $error("moisture exp %0d got %0d", exp_r.moisture, out_chan.moisture);
          err_count++;
        end
        if (out_chan.temperature !== exp_r.temperature) begin
          $error("temperature exp %0d got %0d", exp_r.temperature, out_chan.temperature);
          err_count++;
        end
      end
      @(negedge clk);
    end
  end

  task automatic send_tile(logic [TILE_X_W-1:0] tx, logic [TILE_Y_W-1:0] ty);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.tile_x <= tx;
    in_chan.tile_y <= ty;
    do @(posedge clk); while (!in_chan.ready);
    pending_tiles.push_back(classify_tile(tx, ty));
    @(negedge clk);
  endtask

  task automatic drain_pipeline();
    in_chan.valid <= 1'b0;
    while (pending_tiles.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_threshold(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    thresholds[idx] = val;
  endtask

  task automatic test_directed_corners();
    send_tile('0, '0);
    send_tile('1, '1);
    send_tile('1, '0);
    send_tile('0, '1);
    send_tile(9'd99, 8'd127);
    send_tile(9'd100, 8'd128);
    send_tile(9'd255, 8'd129);
    send_tile(9'd256, 8'd200);
    for (int i = 0; i < 9; i++) send_tile(TILE_X_W'(1 << i), TILE_Y_W'(1 << (i % 8)));
  endtask

  task automatic test_random_tiles(int count);
    for (int i = 0; i < count; i++) begin
      send_tile(TILE_X_W'($urandom_range(0, 511)), TILE_Y_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_threshold_extremes();
    drain_pipeline();
    for (int r = 0; r < CFG_N; r++) write_threshold(cfg_idx_t'(r), '0);
    test_random_tiles(60);
    drain_pipeline();
    for (int r = 0; r < CFG_N; r++) write_threshold(cfg_idx_t'(r), '1);
    test_random_tiles(60);
    drain_pipeline();
    // open up the elevation bands so the climate branches are reached
    write_threshold(REG_OCEAN, 16'd0);
    write_threshold(REG_VOLCANO, 16'hffff);
    write_threshold(REG_MOUNT, 16'hffff);
    for (int p = 0; p < 4; p++) begin
      write_threshold(REG_ICE, CFG_W'($urandom_range(0, 30000)));
      write_threshold(REG_TUNDRA, CFG_W'($urandom_range(0, 40000)));
      write_threshold(REG_HOT, CFG_W'($urandom_range(10000, 50000)));
      write_threshold(REG_DRY, CFG_W'($urandom_range(15000, 35000)));
      write_threshold(REG_WET, CFG_W'($urandom_range(25000, 45000)));
      test_random_tiles(80);
      drain_pipeline();
    end
    for (int r = 0; r < CFG_N; r++) write_threshold(cfg_idx_t'(r), CFG_RESET[r]);
  endtask

  initial begin
    fill_cos_table();
    for (int r = 0; r < CFG_N; r++) thresholds[r] = CFG_RESET[r];
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_corners();
    test_random_tiles(200);
    test_threshold_extremes();
    test_random_tiles(200);
    drain_pipeline();
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/nbtg_pkg.sv
rtl/core/nbtg_if.sv
rtl/core/noise_biome_tile_generator_core.sv
rtl/core/nbtg_checker.sv
bench/noise_biome_tile_generator_core_test.sv
